FILE: rtl/sm4_pkg.sv
// shared types, constants and transform functions for the sm4 cipher core
package sm4_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned Rounds     = 32;
  localparam int unsigned RoundWidth = $clog2(Rounds);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIRECTION = 2'd2;

  // system parameter fk
  localparam word_t FK0 = 32'hA3B1BAC6;
  localparam word_t FK1 = 32'h56AA3350;
  localparam word_t FK2 = 32'h677D9197;
  localparam word_t FK3 = 32'hB27022DC;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_HOLD
  } state_t;

  typedef enum logic {
    MODE_DATA,
    MODE_KEY
  } unit_mode_t;

  // round key store access
  typedef struct packed {
    logic                  we;
    logic [RoundWidth-1:0] waddr;
    logic [RoundWidth-1:0] raddr;
  } ks_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // byte-wise s-box substitution
  function automatic word_t sub_word(input word_t a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  // linear transform for data rounds
  function automatic word_t l_data(input word_t b);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  // linear transform for key schedule
  function automatic word_t l_key(input word_t b);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // ck constant: byte j is (4*i + j) * 7 mod 256, byte 0 on top
  function automatic word_t ck_word(input logic [RoundWidth-1:0] i);
    word_t      w;
    logic [7:0] idx;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      idx = {1'b0, i, 2'b00} + 8'(j);
      w[31-8*j -: 8] = 8'(idx * 8'd7);
    end
    return w;
  endfunction

endpackage

FILE: rtl/sm4_round_unit.sv
// shared round datapath: s-box, linear transform and xor for rounds and key steps
module sm4_round_unit (
  input  sm4_pkg::unit_mode_t mode,
  input  sm4_pkg::word_t      w0,
  input  sm4_pkg::word_t      w1,
  input  sm4_pkg::word_t      w2,
  input  sm4_pkg::word_t      w3,
  input  sm4_pkg::word_t      rk,
  output sm4_pkg::word_t      nx
);
  import sm4_pkg::*;

  word_t mix_in;
  word_t subst;
  word_t lin;

  always_comb begin
    mix_in = w1 ^ w2 ^ w3 ^ rk;
    subst  = sub_word(mix_in);
    lin    = (mode == MODE_KEY) ? l_key(subst) : l_data(subst);
    nx     = w0 ^ lin;
  end

endmodule

FILE: rtl/sm4_key_store.sv
// round key memory, one write port and one registered read port
module sm4_key_store (
  input  logic              clk,
  input  sm4_pkg::ks_ctrl_t ctrl,
  input  sm4_pkg::word_t    wdata,
  output sm4_pkg::word_t    rdata
);
  import sm4_pkg::*;

  word_t mem [Rounds];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.waddr] <= wdata;
    end
    rdata <= mem[ctrl.raddr];
  end

endmodule

FILE: rtl/sm4_block_cipher.sv
// sm4 block cipher top level: sequencer, key schedule and round state
// a new block is accepted only in the idle state, so one block finishes before the next is taken
// a block that finds the keys unexpanded, as after a key write, runs the key expansion first
// the shared round unit does one round or one key step per cycle; that loop sets the rate
// a result waiting in the output register does not block the next input transfer
// reset (synchronous, active high): idle, key cleared, encrypt selected, keys not expanded
module sm4_block_cipher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_en,
  input  logic [sm4_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [sm4_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [63:0]                      block_high,
  input  logic [63:0]                      block_low,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [63:0]                      result_high,
  output logic [63:0]                      result_low
);
  import sm4_pkg::*;

  // control state
  state_t                state;
  state_t                state_next;
  logic [RoundWidth-1:0] cnt;
  logic                  keys_ready;
  logic                  direction;
  logic [63:0]           key_high;
  logic [63:0]           key_low;

  // working words: x for the block, k for the key schedule
  word_t x [4];
  word_t k [4];

  // shared unit hookup
  unit_mode_t            mode;
  word_t                 op0, op1, op2, op3, op_rk;
  word_t                 unit_out;
  word_t                 rk_q;
  ks_ctrl_t              ks_ctrl;
  logic [RoundWidth-1:0] next_idx;

  logic in_xfer;
  logic last_step;
  logic out_free;
  logic key_write;

  assign in_xfer   = in_valid && in_ready;
  assign last_step = (cnt == RoundWidth'(Rounds - 1));
  assign out_free  = !out_valid || out_ready;
  assign key_write = cfg_en && ((cfg_index == CFG_KEY_HIGH) || (cfg_index == CFG_KEY_LOW));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = keys_ready ? ST_LOAD : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (last_step) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (last_step) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: operand select and key store access
  always_comb begin
    in_ready = 1'b0;
    mode     = MODE_DATA;
    op0      = x[0];
    op1      = x[1];
    op2      = x[2];
    op3      = x[3];
    op_rk    = rk_q;
    // fetch one round ahead; decrypt walks the store backwards
    next_idx      = (state == ST_LOAD) ? '0 : cnt + RoundWidth'(1);
    ks_ctrl.we    = 1'b0;
    ks_ctrl.waddr = cnt;
    ks_ctrl.raddr = direction ? next_idx : ~next_idx;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_EXPAND: begin
        mode       = MODE_KEY;
        op0        = k[0];
        op1        = k[1];
        op2        = k[2];
        op3        = k[3];
        op_rk      = ck_word(cnt);
        ks_ctrl.we = 1'b1;
      end
      ST_LOAD, ST_ROUND, ST_HOLD: ;
      default: ;
    endcase
  end

  sm4_round_unit u_round (
    .mode (mode),
    .w0   (op0),
    .w1   (op1),
    .w2   (op2),
    .w3   (op3),
    .rk   (op_rk),
    .nx   (unit_out)
  );

  sm4_key_store u_keys (
    .clk   (clk),
    .ctrl  (ks_ctrl),
    .wdata (unit_out),
    .rdata (rk_q)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      keys_ready <= 1'b0;
      direction  <= 1'b1;
      key_high   <= '0;
      key_low    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_EXPAND) || (state == ST_ROUND)) begin
        cnt <= cnt + RoundWidth'(1);
      end else begin
        cnt <= '0;
      end

      // any key write forces a fresh expansion, even with the same value
      if (key_write) begin
        keys_ready <= 1'b0;
      end else if ((state == ST_EXPAND) && last_step) begin
        keys_ready <= 1'b1;
      end

      if (cfg_en) begin
        unique case (cfg_index)
          CFG_KEY_HIGH:  key_high  <= cfg_data;
          CFG_KEY_LOW:   key_low   <= cfg_data;
          CFG_DIRECTION: direction <= cfg_data[0];
          default: ;
        endcase
      end

      if ((state == ST_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x[0] <= block_high[63:32];
      x[1] <= block_high[31:0];
      x[2] <= block_low[63:32];
      x[3] <= block_low[31:0];
      k[0] <= key_high[63:32] ^ FK0;
      k[1] <= key_high[31:0] ^ FK1;
      k[2] <= key_low[63:32] ^ FK2;
      k[3] <= key_low[31:0] ^ FK3;
    end else if (state == ST_EXPAND) begin
      k[0] <= k[1];
      k[1] <= k[2];
      k[2] <= k[3];
      k[3] <= unit_out;
    end else if (state == ST_ROUND) begin
      x[0] <= x[1];
      x[1] <= x[2];
      x[2] <= x[3];
      x[3] <= unit_out;
    end

    // final words leave in reversed order
    if ((state == ST_HOLD) && out_free) begin
      result_high <= {x[3], x[2]};
      result_low  <= {x[1], x[0]};
    end
  end

`ifndef SYNTHESIS
  // a block arriving without expanded keys starts the key schedule at step zero
  a_expand_first: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !keys_ready |=> (state == ST_EXPAND) && (cnt == '0))
    else $error("block accepted without keys did not start expansion");

  // completing the schedule marks the keys usable unless a key write lands
  a_keys_set: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXPAND) && last_step && !key_write |=> keys_ready)
    else $error("key expansion finished but keys not marked ready");

  // a held result moves to the output register once the slot is free
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) && out_free |=> out_valid && (state == ST_IDLE))
    else $error("finished block not handed to the output register");

  // the round loop always runs its full length before holding
  a_round_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) && $past(state == ST_ROUND) |-> $past(last_step))
    else $error("round loop left early");
`endif

endmodule

FILE: sim/sm4_block_cipher_tb.sv
// self-checking testbench for the sm4_block_cipher core, with its own cipher predictor
`timescale 1ns / 1ps

module sm4_block_cipher_tb;
  import sm4_pkg::*;

  // spare register index, decoded by nothing in the core
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  // system parameter fk, kept apart from the package copy
  localparam logic [31:0] FK_A = 32'hA3B1BAC6;
  localparam logic [31:0] FK_B = 32'h56AA3350;
  localparam logic [31:0] FK_C = 32'h677D9197;
  localparam logic [31:0] FK_D = 32'hB27022DC;

  // receiver stall behaviors
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_block_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_en = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = CFG_KEY_HIGH;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [63:0]          block_high = '0;
  logic [63:0]          block_low = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [63:0]          result_high;
  logic [63:0]          result_low;

  sm4_block_cipher dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .block_high  (block_high),
    .block_low   (block_low),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_high (result_high),
    .result_low  (result_low)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // s-box, an independent copy of the standard table
  logic [7:0] sbox_ref [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  // predictor copy of the core state: key, direction and the expanded schedule
  logic [63:0]   key_hi_m = '0;
  logic [63:0]   key_lo_m = '0;
  logic          encrypt_m = 1'b1;
  logic [31:0]   sched [32];
  logic          sched_valid = 1'b0;

  // blocks accepted by the core whose results have not yet been transferred
  cipher_block_t pending_cipher [$];
  int unsigned   mismatch_count = 0;
  int unsigned   blocks_sent = 0;

  // sender burst state
  int unsigned   burst_left = 1;
  int unsigned   gap_len;
  bit            valid_up = 1'b0;

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] tau(input logic [31:0] a);
    return {sbox_ref[a[31:24]], sbox_ref[a[23:16]], sbox_ref[a[15:8]], sbox_ref[a[7:0]]};
  endfunction

  // full sm4 transform of one block; expands the key first if a key write
  // has invalidated the schedule
  function automatic cipher_block_t cipher_block(input logic [63:0] hi, input logic [63:0] lo);
    logic [31:0]   k [4];
    logic [31:0]   x [4];
    logic [31:0]   t;
    logic [31:0]   rk;
    cipher_block_t r;
    if (!sched_valid) begin
      k[0] = key_hi_m[63:32] ^ FK_A;
      k[1] = key_hi_m[31:0]  ^ FK_B;
      k[2] = key_lo_m[63:32] ^ FK_C;
      k[3] = key_lo_m[31:0]  ^ FK_D;
      for (int i = 0; i < 32; i++) begin
        t = k[1] ^ k[2] ^ k[3];
        // ck byte j of step i is (4i+j)*7 mod 256, most significant first
        for (int j = 0; j < 4; j++)
          t[31-8*j -: 8] = t[31-8*j -: 8] ^ 8'((4 * i + j) * 7);
        t = tau(t);
        t = k[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
        k[0] = k[1];
        k[1] = k[2];
        k[2] = k[3];
        k[3] = t;
        sched[i] = t;
      end
      sched_valid = 1'b1;
    end
    x = '{hi[63:32], hi[31:0], lo[63:32], lo[31:0]};
    for (int i = 0; i < 32; i++) begin
      rk = encrypt_m ? sched[i] : sched[31-i];
      t = tau(x[1] ^ x[2] ^ x[3] ^ rk);
      t = x[0] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = t;
    end
    r.hi = {x[3], x[2]};
    r.lo = {x[1], x[0]};
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // key material: mostly random, now and then all zeros or all ones
  function automatic logic [63:0] key_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return rand64();
    endcase
  endfunction

  // register write; the enable drops once the write is clocked in, so back-to-back calls
  // never assign cfg_en twice in one step
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    case (idx)
      CFG_KEY_HIGH: begin
        key_hi_m    = val;
        sched_valid = 1'b0;
      end
      CFG_KEY_LOW: begin
        key_lo_m    = val;
        sched_valid = 1'b0;
      end
      CFG_DIRECTION: encrypt_m = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one input transfer; valid stays up across a burst and drops for a random gap
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    in_valid   <= 1'b1;
    block_high <= hi;
    block_low  <= lo;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_ready);
    // transfer happened at this edge: predict now, in acceptance order
    pending_cipher.push_back(cipher_block(hi, lo));
    blocks_sent++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      // a quarter of the bursts run straight into the next one
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        valid_up = 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  // stop sending and hold off until every pending result has been transferred
  task automatic wait_all_results();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (pending_cipher.size() != 0) @(posedge clk);
  endtask

  // all-zero key and block straight out of reset, so the first block also
  // triggers the first key expansion with the reset key and encrypt direction
  task automatic test_reset_defaults();
    send_block('0, '0);
    send_block(rand64(), rand64());
    wait_all_results();
  endtask

  // standard test vector, encrypted and then decrypted back
  task automatic test_standard_vector();
    write_reg(CFG_KEY_HIGH, 64'h0123456789ABCDEF);
    write_reg(CFG_KEY_LOW, 64'hFEDCBA9876543210);
    send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    wait_all_results();
    write_reg(CFG_DIRECTION, 64'd0);
    send_block(64'h681EDF34D206965E, 64'h86B3E94F536E4246);
    wait_all_results();
  endtask

  // block field extremes in both directions
  task automatic test_block_extremes();
    send_block('0, '1);
    send_block('1, '0);
    send_block(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
    wait_all_results();
    write_reg(CFG_DIRECTION, 64'd1);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    send_block(64'h0000000000000001, 64'h8000000000000000);
    send_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
    send_block(64'h00000000FFFFFFFF, 64'hFFFFFFFF00000000);
    wait_all_results();
  endtask

  // key rewrite with an unchanged value, single key halves, key extremes,
  // direction writes with junk in the upper bits, and the spare index
  task automatic test_register_cases();
    write_reg(CFG_KEY_HIGH, key_hi_m);
    send_block(rand64(), rand64());
    wait_all_results();
    write_reg(CFG_KEY_LOW, '1);
    send_block(rand64(), rand64());
    wait_all_results();
    write_reg(CFG_KEY_HIGH, '1);
    send_block(rand64(), rand64());
    wait_all_results();
    write_reg(CFG_KEY_HIGH, '0);
    write_reg(CFG_KEY_LOW, '0);
    send_block(rand64(), rand64());
    wait_all_results();
    // only bit 0 of a direction write counts, and no re-expansion follows
    write_reg(CFG_DIRECTION, 64'hFFFFFFFFFFFFFFFE);
    send_block(rand64(), rand64());
    send_block(rand64(), rand64());
    wait_all_results();
    write_reg(CFG_DIRECTION, 64'h8000000000000001);
    send_block(rand64(), rand64());
    wait_all_results();
    // the spare index must leave key, schedule and direction alone
    write_reg(CFG_SPARE, rand64());
    send_block(rand64(), rand64());
    send_block(rand64(), rand64());
    wait_all_results();
  endtask

  // random phases: a random set of register writes between fully drained
  // runs of random blocks
  task automatic test_random_traffic();
    int unsigned run_len;
    logic [63:0] hi;
    logic [63:0] lo;
    while (blocks_sent < 1150) begin
      case ($urandom_range(0, 5))
        0: begin
          write_reg(CFG_KEY_HIGH, key_value());
          write_reg(CFG_KEY_LOW, key_value());
        end
        1: write_reg(CFG_KEY_HIGH, key_value());
        2: write_reg(CFG_KEY_LOW, key_value());
        3: write_reg(CFG_DIRECTION, rand64());
        4: write_reg(CFG_SPARE, rand64());
        default: ;
      endcase
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_DIRECTION, rand64());
      run_len = $urandom_range(5, 60);
      repeat (run_len) begin
        hi = rand64();
        lo = rand64();
        // occasional saturated halves
        case ($urandom_range(0, 15))
          0:       hi = '0;
          1:       hi = '1;
          2:       lo = '0;
          3:       lo = '1;
          default: ;
        endcase
        send_block(hi, lo);
      end
      wait_all_results();
    end
  endtask

  // receiver: ready follows one of several stall patterns, switching now and then
  rx_mode_t    rx_mode = RX_STREAM;
  int unsigned rx_mode_left = 0;
  logic [4:0]  rx_phase = '0;

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(50, 400);
    end
    rx_mode_left--;
    rx_phase++;
    case (rx_mode)
      RX_STREAM:  out_ready <= 1'b1;
      RX_COIN:    out_ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE:  out_ready <= ($urandom_range(0, 7) == 0);
      default:    out_ready <= (rx_phase >= 5'd20);   // long periodic stall
    endcase
  end

  // result checker: every output transfer against the oldest prediction
  always @(posedge clk) begin : check_results
    cipher_block_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cipher.size() == 0) begin
        $error("result transfer with no block pending: %h %h", result_high, result_low);
        mismatch_count++;
      end else begin
        want = pending_cipher.pop_front();
        if (result_high !== want.hi) begin
          $error("result_high: expected %h, got %h", want.hi, result_high);
          mismatch_count++;
        end
        if (result_low !== want.lo) begin
          $error("result_low: expected %h, got %h", want.lo, result_low);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_standard_vector();
    test_block_extremes();
    test_register_cases();
    test_random_traffic();
    wait_all_results();
    // room for a stray result after the last one
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
